@@ hdl/rdq_pkg.sv @@
// package: constants, codes, types and helpers of the ring deque
`default_nettype none
package rdq_pkg;

  localparam int DEPTH   = 64;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int IDX_W   = 7;
  localparam int SUM_W   = IDX_W + 1;
  localparam int DATA_W  = 8;
  localparam int OP_W    = 4;
  localparam int STAT_W  = 2;
  localparam int APB_W   = 32;
  localparam int PADDR_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 4'd0,
    OP_PUSH_FRONT = 4'd1,
    OP_POP_BACK   = 4'd2,
    OP_POP_FRONT  = 4'd3,
    OP_READ_AT    = 4'd4,
    OP_WRITE_AT   = 4'd5,
    OP_INSERT     = 4'd6,
    OP_ERASE      = 4'd7,
    OP_CLEAR      = 4'd8
  } op_e;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  localparam logic [PADDR_W-3:0] REG_CAPACITY = '0;

  typedef struct packed {
    logic             clear;
    logic [IDX_W-1:0] cap;
  } cfg_t;

  // physical slot of a logical position, head < cap and pos <= cap
  function automatic logic [ADDR_W-1:0] slot(input logic [ADDR_W-1:0] head,
                                             input logic [IDX_W-1:0]  pos,
                                             input logic [IDX_W-1:0]  cap);
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] wrapped;
    sum     = SUM_W'(head) + SUM_W'(pos);
    wrapped = (sum >= SUM_W'(cap)) ? sum - SUM_W'(cap) : sum;
    return wrapped[ADDR_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] head_inc(input logic [ADDR_W-1:0] head,
                                                 input logic [IDX_W-1:0]  cap);
    logic [IDX_W-1:0] nxt;
    nxt = IDX_W'(head) + IDX_W'(1);
    return (nxt == cap) ? '0 : nxt[ADDR_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ hdl/rdq_if.sv @@
// interfaces: request and response channels of the ring deque
`default_nettype none
interface rdq_req_if;
  logic                        valid;
  logic                        ready;
  logic [rdq_pkg::OP_W-1:0]    op;
  logic [rdq_pkg::DATA_W-1:0]  data_in;
  logic [rdq_pkg::IDX_W-1:0]   index;
  logic [rdq_pkg::IDX_W-1:0]   index_end;

  modport source (output valid, op, data_in, index, index_end, input ready);
  modport sink   (input valid, op, data_in, index, index_end, output ready);
endinterface

interface rdq_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [rdq_pkg::DATA_W-1:0]  data_out;
  logic [rdq_pkg::STAT_W-1:0]  status;
  logic [rdq_pkg::IDX_W-1:0]   count;
  logic                        is_full;
  logic                        is_empty;

  modport source (output valid, data_out, status, count, is_full, is_empty, input ready);
  modport sink   (input valid, data_out, status, count, is_full, is_empty, output ready);
endinterface
`default_nettype wire

@@ hdl/ring_deque_with_overwrite_unit.sv @@
// Byte ring deque with overwrite: the elements sit in a 64-entry single-write,
// single-read memory with registered read data, and head and fill are held
// in registers beside it. Requests are taken one at a time. Read_at waits for
// the memory read before its result; insert and erase move elements one by one
// (erase of an empty range moves none), each move a memory read followed by a
// write of the read data in the cycle after. A finished result waits in an
// output register, and a new request is taken while it waits. The store has no
// clearing pass; capacity is read and written at word address 0 (byte addresses
// 0 to 3) and a write to it empties the deque.
`default_nettype none
module ring_deque_with_overwrite_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  rdq_req_if.sink                            req,
  rdq_rsp_if.source                          rsp,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rdq_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [rdq_pkg::APB_W-1:0]     pwdata,
  output logic      [rdq_pkg::APB_W-1:0]     prdata,
  output logic                               pready
);

  logic [rdq_pkg::IDX_W-1:0]     cap_q, cap_d;
  logic [rdq_pkg::PADDR_W-3:0]   reg_idx;
  logic                          cap_wr;
  logic [rdq_pkg::IDX_W-1:0]     cap_eff;
  rdq_pkg::cfg_t                 cfg;

  assign pready  = 1'b1;
  assign reg_idx = paddr[rdq_pkg::PADDR_W-1:2];
  assign cap_wr  = psel && penable && pwrite && pready && (reg_idx == rdq_pkg::REG_CAPACITY);
  assign cap_d   = cap_wr ? pwdata[rdq_pkg::IDX_W-1:0] : cap_q;
  assign prdata  = (reg_idx == rdq_pkg::REG_CAPACITY) ? rdq_pkg::APB_W'(cap_q) : '0;

  // saturate to 1..DEPTH
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = rdq_pkg::IDX_W'(1);
    end else if (cap_q > rdq_pkg::IDX_W'(rdq_pkg::DEPTH)) begin
      cap_eff = rdq_pkg::IDX_W'(rdq_pkg::DEPTH);
    end else begin
      cap_eff = cap_q;
    end
  end

  assign cfg.clear = cap_wr;
  assign cfg.cap   = cap_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= rdq_pkg::IDX_W'(rdq_pkg::DEPTH);
    end else begin
      cap_q <= cap_d;
    end
  end

  rdq_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .req    (req),
    .rsp    (rsp)
  );

endmodule
`default_nettype wire

@@ hdl/rdq_ram.sv @@
// generic ram: one write port, one read port with registered read data
`default_nettype none
module rdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ hdl/rdq_core.sv @@
// core: operation sequencer, head and fill pointers, result register
`default_nettype none
module rdq_core (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire rdq_pkg::cfg_t cfg_i,
  rdq_req_if.sink        req,
  rdq_rsp_if.source      rsp
);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_RDWAIT, S_INS_RD, S_INS_WR, S_ER_RD, S_ER_WR, S_FIN
  } state_e;

  state_e                        state_q, state_d;
  logic [rdq_pkg::ADDR_W-1:0]    head_q, head_d;
  logic [rdq_pkg::IDX_W-1:0]     fill_q, fill_d;
  logic [rdq_pkg::OP_W-1:0]      op_q, op_d;
  logic [rdq_pkg::DATA_W-1:0]    data_q, data_d;
  logic [rdq_pkg::IDX_W-1:0]     idx_q, idx_d;
  logic [rdq_pkg::IDX_W-1:0]     end_q, end_d;
  logic [rdq_pkg::IDX_W-1:0]     i_q, i_d;
  logic [rdq_pkg::STAT_W-1:0]    status_q, status_d;
  logic                          rd_ok_q, rd_ok_d;
  logic                          out_valid_q, out_valid_d;
  logic [rdq_pkg::DATA_W-1:0]    out_data_q, out_data_d;
  logic [rdq_pkg::STAT_W-1:0]    out_status_q, out_status_d;
  logic [rdq_pkg::IDX_W-1:0]     out_count_q, out_count_d;
  logic                          out_full_q, out_full_d;
  logic                          out_empty_q, out_empty_d;

  logic                          we;
  logic [rdq_pkg::ADDR_W-1:0]    waddr;
  logic [rdq_pkg::DATA_W-1:0]    wdata;
  logic                          re;
  logic [rdq_pkg::ADDR_W-1:0]    raddr;
  logic [rdq_pkg::DATA_W-1:0]    rdata;

  logic                          done;
  logic [rdq_pkg::IDX_W-1:0]     cap;
  logic [rdq_pkg::IDX_W-1:0]     gap;
  logic [rdq_pkg::SUM_W-1:0]     src_pos;
  logic [rdq_pkg::IDX_W-1:0]     fill_m1;
  logic [rdq_pkg::IDX_W-1:0]     cap_m1;

  rdq_ram #(
    .WIDTH (rdq_pkg::DATA_W),
    .DEPTH (rdq_pkg::DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign req.ready    = (state_q == S_IDLE);
  assign rsp.valid    = out_valid_q;
  assign rsp.data_out = out_data_q;
  assign rsp.status   = out_status_q;
  assign rsp.count    = out_count_q;
  assign rsp.is_full  = out_full_q;
  assign rsp.is_empty = out_empty_q;

  assign cap     = cfg_i.cap;
  assign gap     = end_q - idx_q;
  assign src_pos = rdq_pkg::SUM_W'(i_q) + rdq_pkg::SUM_W'(gap);
  assign fill_m1 = fill_q - rdq_pkg::IDX_W'(1);
  assign cap_m1  = cap - rdq_pkg::IDX_W'(1);

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    fill_d       = fill_q;
    op_d         = op_q;
    data_d       = data_q;
    idx_d        = idx_q;
    end_d        = end_q;
    i_d          = i_q;
    status_d     = status_q;
    rd_ok_d      = rd_ok_q;
    out_valid_d  = out_valid_q && !rsp.ready;
    out_data_d   = out_data_q;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    out_full_d   = out_full_q;
    out_empty_d  = out_empty_q;
    we           = 1'b0;
    waddr        = '0;
    wdata        = '0;
    re           = 1'b0;
    raddr        = '0;
    done         = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (req.valid) begin
          op_d     = req.op;
          data_d   = req.data_in;
          idx_d    = req.index;
          end_d    = req.index_end;
          status_d = rdq_pkg::ST_OK;
          rd_ok_d  = 1'b0;
          state_d  = S_EXEC;
        end
      end
      S_EXEC: begin
        case (op_q)
          rdq_pkg::OP_PUSH_BACK: begin
            we    = 1'b1;
            wdata = data_q;
            if (fill_q == cap) begin
              waddr  = head_q;
              head_d = rdq_pkg::head_inc(head_q, cap);
            end else begin
              waddr  = rdq_pkg::slot(head_q, fill_q, cap);
              fill_d = fill_q + rdq_pkg::IDX_W'(1);
            end
            done = 1'b1;
          end
          rdq_pkg::OP_PUSH_FRONT: begin
            head_d = (head_q == '0) ? cap_m1[rdq_pkg::ADDR_W-1:0]
                                    : head_q - rdq_pkg::ADDR_W'(1);
            we     = 1'b1;
            waddr  = head_d;
            wdata  = data_q;
            if (fill_q < cap) begin
              fill_d = fill_q + rdq_pkg::IDX_W'(1);
            end
            done = 1'b1;
          end
          rdq_pkg::OP_POP_BACK: begin
            if (fill_q == '0) begin
              status_d = rdq_pkg::ST_EMPTY;
            end else begin
              fill_d = fill_m1;
            end
            done = 1'b1;
          end
          rdq_pkg::OP_POP_FRONT: begin
            if (fill_q == '0) begin
              status_d = rdq_pkg::ST_EMPTY;
            end else begin
              fill_d = fill_m1;
              head_d = rdq_pkg::head_inc(head_q, cap);
            end
            done = 1'b1;
          end
          rdq_pkg::OP_READ_AT: begin
            if (idx_q >= fill_q) begin
              status_d = rdq_pkg::ST_RANGE;
              done     = 1'b1;
            end else begin
              re      = 1'b1;
              raddr   = rdq_pkg::slot(head_q, idx_q, cap);
              state_d = S_RDWAIT;
            end
          end
          rdq_pkg::OP_WRITE_AT: begin
            if (idx_q >= fill_q) begin
              status_d = rdq_pkg::ST_RANGE;
            end else begin
              we    = 1'b1;
              waddr = rdq_pkg::slot(head_q, idx_q, cap);
              wdata = data_q;
            end
            done = 1'b1;
          end
          rdq_pkg::OP_INSERT: begin
            if (idx_q > fill_q) begin
              status_d = rdq_pkg::ST_RANGE;
              done     = 1'b1;
            end else begin
              // full: drop the front element first
              if (fill_q == cap) begin
                head_d = rdq_pkg::head_inc(head_q, cap);
                fill_d = fill_m1;
                i_d    = fill_m1;
                idx_d  = (idx_q > fill_m1) ? fill_m1 : idx_q;
              end else begin
                i_d = fill_q;
              end
              state_d = S_INS_RD;
            end
          end
          rdq_pkg::OP_ERASE: begin
            if (idx_q > end_q || end_q > fill_q) begin
              status_d = rdq_pkg::ST_RANGE;
              done     = 1'b1;
            end else if (gap == '0) begin
              done = 1'b1;
            end else begin
              i_d     = idx_q;
              state_d = S_ER_RD;
            end
          end
          rdq_pkg::OP_CLEAR: begin
            head_d = '0;
            fill_d = '0;
            done   = 1'b1;
          end
          default: begin
            status_d = rdq_pkg::ST_RANGE;
            done     = 1'b1;
          end
        endcase
      end
      S_RDWAIT: begin
        rd_ok_d = 1'b1;
        done    = 1'b1;
      end
      S_INS_RD: begin
        if (i_q > idx_q) begin
          re      = 1'b1;
          raddr   = rdq_pkg::slot(head_q, i_q - rdq_pkg::IDX_W'(1), cap);
          state_d = S_INS_WR;
        end else begin
          we     = 1'b1;
          waddr  = rdq_pkg::slot(head_q, idx_q, cap);
          wdata  = data_q;
          fill_d = fill_q + rdq_pkg::IDX_W'(1);
          done   = 1'b1;
        end
      end
      S_INS_WR: begin
        we      = 1'b1;
        waddr   = rdq_pkg::slot(head_q, i_q, cap);
        wdata   = rdata;
        i_d     = i_q - rdq_pkg::IDX_W'(1);
        state_d = S_INS_RD;
      end
      S_ER_RD: begin
        if (src_pos < rdq_pkg::SUM_W'(fill_q)) begin
          re      = 1'b1;
          raddr   = rdq_pkg::slot(head_q, src_pos[rdq_pkg::IDX_W-1:0], cap);
          state_d = S_ER_WR;
        end else begin
          fill_d = fill_q - gap;
          done   = 1'b1;
        end
      end
      S_ER_WR: begin
        we      = 1'b1;
        waddr   = rdq_pkg::slot(head_q, i_q, cap);
        wdata   = rdata;
        i_d     = i_q + rdq_pkg::IDX_W'(1);
        state_d = S_ER_RD;
      end
      S_FIN: begin
        done = 1'b1;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (done) begin
      if (!out_valid_q || rsp.ready) begin
        out_valid_d  = 1'b1;
        out_data_d   = rd_ok_d ? rdata : '0;
        out_status_d = status_d;
        out_count_d  = fill_d;
        out_full_d   = (fill_d == cap);
        out_empty_d  = (fill_d == '0);
        state_d      = S_IDLE;
      end else begin
        state_d = S_FIN;
      end
    end

    if (cfg_i.clear) begin
      head_d = '0;
      fill_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      head_q       <= '0;
      fill_q       <= '0;
      op_q         <= '0;
      data_q       <= '0;
      idx_q        <= '0;
      end_q        <= '0;
      i_q          <= '0;
      status_q     <= rdq_pkg::ST_OK;
      rd_ok_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
      out_status_q <= rdq_pkg::ST_OK;
      out_count_q  <= '0;
      out_full_q   <= 1'b0;
      out_empty_q  <= 1'b1;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      fill_q       <= fill_d;
      op_q         <= op_d;
      data_q       <= data_d;
      idx_q        <= idx_d;
      end_q        <= end_d;
      i_q          <= i_d;
      status_q     <= status_d;
      rd_ok_q      <= rd_ok_d;
      out_valid_q  <= out_valid_d;
      out_data_q   <= out_data_d;
      out_status_q <= out_status_d;
      out_count_q  <= out_count_d;
      out_full_q   <= out_full_d;
      out_empty_q  <= out_empty_d;
    end
  end

endmodule
`default_nettype wire
